[sv/cht_pkg.sv]
// Package for the chained hash table: operation and status codes, widths.
// No dependencies; used by cht_ctrl, cht_dp and chained_hash_table.
package cht_pkg;
    localparam int KEY_W = 32;
    localparam int HASH_W = 16;
    localparam int BIDX_W = 6;
    localparam int CNT_W = 7;
    localparam int STAT_W = 2;
    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd10;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, start hash
        logic hash_step; // advance hash pipeline
        logic div_start; // load the divider
        logic div_step;  // one quotient bit
        logic scan_rd;   // issue slot read
        logic scan_adv;  // next slot
        logic commit;    // write decision, load output
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic init_done; // key RAM clearing pass finished
        logic hash_done;
        logic div_done;
        logic scan_last;
        logic hit;
    } t_sts;
endpackage

[sv/cht_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[sv/cht_ctrl.sv]
// Controller state machine of the chained hash table.
// Depends on cht_pkg.
module cht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cht_pkg::t_cmd o_cmd,
    input  cht_pkg::t_sts i_sts
);
    import cht_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HASH = 6'b000010,
        S_DIV  = 6'b000100,
        S_RD   = 6'b001000,
        S_CHK  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // held off until the key RAM has been cleared
                o_in_ready = i_sts.init_done;
                if (i_in_valid && i_sts.init_done) begin
                    o_cmd.load = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.hit || i_sts.scan_last) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[sv/cht_dp.sv]
// Datapath of the chained hash table: hash pipeline, restoring divider,
// slot scan over the key RAM, which holds a valid bit beside each key.
// Depends on cht_pkg, cht_ram.
module cht_dp #(
    parameter int MAX_BUCKETS = 64,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cht_pkg::CNT_W-1:0] i_cfg_data,
    input  logic [1:0]                i_mode,
    input  logic [cht_pkg::KEY_W-1:0] i_key,
    input  cht_pkg::t_cmd             i_cmd,
    output cht_pkg::t_sts             o_sts,
    output logic [cht_pkg::STAT_W-1:0] o_status,
    output logic [cht_pkg::HASH_W-1:0] o_hash,
    output logic [cht_pkg::BIDX_W-1:0] o_bidx
);
    import cht_pkg::*;

    localparam int SLOTS = MAX_BUCKETS * BUCKET_DEPTH;
    localparam int SA_W = $clog2(SLOTS);
    localparam int BK_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SL_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int CW = $clog2(MAX_BUCKETS + 1);
    localparam int HS_W = 4;
    localparam logic [HS_W-1:0] HASH_LAST = 4'd10;
    localparam logic [CW-1:0] MAXC = CW'(MAX_BUCKETS);

    // configuration register, clamped on write
    logic [CW-1:0] r_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= (CW'(COUNT_RESET) > MAXC) ? MAXC : CW'(COUNT_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_data == '0) r_count <= CW'(1);
            else if (32'(i_cfg_data) > 32'(MAX_BUCKETS)) r_count <= MAXC;
            else r_count <= CW'(i_cfg_data);
        end
    end

    // request capture
    logic [1:0]       r_mode;
    logic [KEY_W-1:0] r_key;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_key <= i_key;
        end
    end

    // hash: one step of the mixing sequence per cycle
    logic [HS_W-1:0] r_hs;
    logic [31:0] r_x, n_x;
    logic [63:0] w_q;
    always_comb begin
        n_x = r_x;
        w_q = '0;
        case (r_hs)
            4'd0: n_x = r_x ^ (r_x << 7);
            4'd1: n_x = r_x ^ (r_x >> 9);
            4'd2: n_x = (r_x + 32'd9407) * 32'd791;
            4'd3: begin
                // divide by 41 via reciprocal: ceil(2^37/41)
                w_q = 64'(r_x) * 64'd3352169597;
                n_x = 32'(w_q >> 37);
            end
            4'd4: n_x = (r_x << 3) - (r_x >> 2);
            4'd5: n_x = r_x * 32'h0000A5A5;
            4'd6: n_x = r_x ^ ((r_x >> 16) * 32'h0000A5A5 & 32'h0000FFFF);
            4'd7: n_x = r_x ^ (r_x >> 5);
            4'd8: n_x = (r_x * 32'd17 + 32'd88) ^ (r_x << 3);
            4'd9: n_x = r_x + (r_x >> 7) * 32'd37;
            default: n_x = r_x;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= {16'd0, i_key[15:0]};
            r_hs <= '0;
        end else if (i_cmd.hash_step && r_hs != HASH_LAST) begin
            r_x <= n_x;
            r_hs <= r_hs + 1'b1;
        end
    end
    assign o_sts.hash_done = (r_hs == HASH_LAST);

    // restoring divider: hash mod count, one quotient bit per cycle
    logic [HASH_W-1:0] r_dq;
    logic [CW-1:0]     r_rem;
    logic [4:0]        r_dn;
    logic [CW:0]       w_trial;
    assign w_trial = {r_rem, r_dq[HASH_W-1]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq <= r_x[HASH_W-1:0];
            r_rem <= '0;
            r_dn <= '0;
        end else if (i_cmd.div_step && !o_sts.div_done) begin
            r_dq <= {r_dq[HASH_W-2:0], 1'b0};
            r_dn <= r_dn + 1'b1;
            if (w_trial >= {1'b0, r_count}) r_rem <= CW'(w_trial - {1'b0, r_count});
            else r_rem <= CW'(w_trial);
        end
    end
    assign o_sts.div_done = (r_dn == 5'(HASH_W));

    // clearing pass after reset: zero every slot, valid bit included
    logic            r_clr_busy;
    logic [SA_W-1:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SA_W'(SLOTS - 1)) r_clr_busy <= 1'b0;
        end
    end
    assign o_sts.init_done = !r_clr_busy;

    // slot scan; read word is {valid, key}
    logic [SL_W-1:0] r_slot;
    logic [SA_W-1:0] w_addr;
    logic [KEY_W:0]  w_rdata;
    logic            w_slot_valid;
    logic [SL_W-1:0] r_free;
    logic r_free_ok;
    logic w_ins;
    assign w_addr = SA_W'(32'(r_rem[BK_W-1:0]) * BUCKET_DEPTH + 32'(r_slot));
    assign w_ins = (r_mode == MODE_INSERT);
    assign w_slot_valid = w_rdata[KEY_W];
    assign o_sts.scan_last = (32'(r_slot) == BUCKET_DEPTH - 1);
    assign o_sts.hit = !w_ins && w_slot_valid && (w_rdata[KEY_W-1:0] == r_key);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_slot <= '0;
            r_free_ok <= 1'b0;
            r_free <= '0;
        end else begin
            if ((i_cmd.scan_adv || i_cmd.commit) && w_ins && !w_slot_valid
                && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free <= r_slot;
            end
            if (i_cmd.scan_adv) r_slot <= r_slot + 1'b1;
        end
    end

    // insert writes the first free slot seen; remove clears the matching slot
    logic w_free_now;
    logic [SL_W-1:0] w_fslot;
    logic [SA_W-1:0] w_waddr;
    assign w_free_now = r_free_ok || !w_slot_valid;
    assign w_fslot = r_free_ok ? r_free : r_slot;
    assign w_waddr = SA_W'(32'(r_rem[BK_W-1:0]) * BUCKET_DEPTH + 32'(w_fslot));

    logic w_key_we;
    assign w_key_we = i_cmd.commit
        && ((w_ins && w_free_now) || (o_sts.hit && r_mode == MODE_REMOVE));

    cht_ram #(.WIDTH(KEY_W + 1), .DEPTH(SLOTS)) u_keys (
        .i_clk   (i_clk),
        .i_we    (r_clr_busy || w_key_we),
        .i_addr  (r_clr_busy ? r_clr_addr : (w_key_we ? w_waddr : w_addr)),
        .i_wdata (r_clr_busy ? (KEY_W + 1)'(0) : {w_ins, r_key}),
        .o_rdata (w_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (w_ins) o_status <= w_free_now ? ST_DONE : ST_FULL;
            else o_status <= o_sts.hit ? ST_DONE : ST_MISS;
            o_hash <= r_x[HASH_W-1:0];
            o_bidx <= BIDX_W'(r_rem);
        end
    end
endmodule

[sv/chained_hash_table.sv]
// Chained hash table of 32-bit keys: each request (insert, remove, lookup)
// is accepted, hashed in ten mixing steps, reduced by the divider to hash
// mod bucket_count and scanned slot by slot in the key RAM (read, then
// compare), then its result is offered. Lookup and remove stop at the first
// match, insert scans the whole bucket; one request at a time, and input is
// held off while the result waits. After reset a clearing pass over all
// MAX_BUCKETS*BUCKET_DEPTH slots (512 by default) empties the table before
// the first request is accepted.
// Depends on cht_pkg, cht_ctrl, cht_dp, cht_ram.
module chained_hash_table #(
    parameter int MAX_BUCKETS = 64,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // mode[1:0], key[33:2], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status[1:0], hash_value[17:2], bucket_index[23:18]
);
    import cht_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic [STAT_W-1:0] w_status;
    logic [HASH_W-1:0] w_hash;
    logic [BIDX_W-1:0] w_bidx;

    cht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    cht_dp #(.MAX_BUCKETS(MAX_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_mode(s_axis_tdata[1:0]), .i_key(s_axis_tdata[33:2]),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .o_status(w_status), .o_hash(w_hash), .o_bidx(w_bidx)
    );

    assign m_axis_tdata = {w_bidx, w_hash, w_status};

    // held result stays stable while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result moved");
    // no new request while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during result");
    // bucket index below MAX_BUCKETS
    a_bidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[23:18]) < MAX_BUCKETS) else $error("bucket range");
endmodule
